### hw/rtl/srwt_pkg.sv
// Shared types and constants for the receive-window tracker.
// No dependencies; imported by every module of the block.
package srwt_pkg;

	localparam int unsigned DEF_MAX_WINDOW_BITS = 256;
	localparam int unsigned DEF_SEQ_SPACE_MAX   = 65535;

	// Window class codes
	localparam logic [1:0] CLS_IN_RANGE  = 2'd0;
	localparam logic [1:0] CLS_IN_WINDOW = 2'd1;
	localparam logic [1:0] CLS_OLD       = 2'd2;
	localparam logic [1:0] CLS_OUTSIDE   = 2'd3;

	// Command kinds
	localparam logic KIND_ARRIVAL = 1'b0;
	localparam logic KIND_ADVANCE = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [15:0] seq_number;
		logic [8:0]  advance_count;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  window_class;
		logic        was_received;
		logic [8:0]  contiguous_count;
		logic [15:0] window_start;
	} result_t;

	// Bitmap store request: one write and one registered read per cycle
	typedef struct packed {
		logic       clear;
		logic       wr_en;
		logic [7:0] wr_addr;
		logic [7:0] wr_data;
		logic [7:0] rd_addr;
		logic       rd_ok;
	} map_req_t;

endpackage

### hw/rtl/srwt_mod_unit.sv
// Shared add/subtract unit modulo SEQ_SPACE_MAX; y lies in 0..SEQ_SPACE_MAX-1.
// Depends on srwt_pkg for defaults.
module srwt_mod_unit
	import srwt_pkg::*;
#(
	parameter int unsigned SEQ_SPACE_MAX = DEF_SEQ_SPACE_MAX
) (
	input  logic [15:0] a,
	input  logic [15:0] b,
	input  logic        sub,
	output logic [15:0] y
);

	localparam logic [17:0] M18 = 18'(SEQ_SPACE_MAX);

	logic [17:0] sum;

	// Operands keep the sum below twice the modulus, so one correction is enough
	always_comb begin
		if (sub) begin
			sum = {2'b00, a} + (M18 - {2'b00, b});
		end else begin
			sum = {2'b00, a} + {2'b00, b};
		end
		if (sum >= M18) begin
			y = 16'(sum - M18);
		end else begin
			y = sum[15:0];
		end
	end

endmodule

### hw/rtl/srwt_map_mem.sv
// Receive bitmap store: byte-wide array with per-entry valid bits, registered read.
// Depends on srwt_pkg for the request struct.
module srwt_map_mem
	import srwt_pkg::*;
#(
	parameter int unsigned DEPTH = DEF_MAX_WINDOW_BITS / 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  map_req_t req,
	output logic [7:0] rdata
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0]       mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [7:0]       rdata_q;
	logic             rd_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.clear) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr[AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr[AW-1:0]] <= req.wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ok_q <= 1'b0;
		end else begin
			rd_ok_q <= req.rd_ok && valid_q[req.rd_addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[req.rd_addr[AW-1:0]];
	end

	// Entries never written, or past the window, read as zero
	assign rdata = rd_ok_q ? rdata_q : 8'h00;

endmodule

### hw/rtl/seq_receive_window_tracker.sv
// Receive-window tracker for a selective-repeat receiver.
// Command in (cmd/start/busy), one result beat out (result/done), window size register.
// A command beat is taken at a clock edge with start high and busy low. busy
// stays high while the sequencer works on it; the result beat then shows on
// result for exactly one cycle with done high. The receiver cannot stall, so
// no result is ever held, and a new command may start in the cycle done is up.
// Steps per command: an arrival computes its offset and the range-end offset,
// classifies, sets its bit and scans on through each further full bitmap byte
// the contiguous run extends into; a first frame goes straight to setting its
// bit. Old and out-of-window numbers finish at classification; invalid numbers
// and an advance before start finish at once. An advance reduces its count,
// steps the window start and rewrites each bitmap byte (window_bits/8) shifted,
// or clears the map when it slides past the whole window. done comes in the
// first idle cycle. The shared modular unit and the single read port of the
// bitmap store set this sequence of steps.
// cfg_we writes window_bits (clamped to 8..MAX_WINDOW_BITS, rounded down to a
// multiple of eight) and restarts the tracker; write it only while idle.
// Reset: window 256 (clamped), not started, bitmap cleared through valid bits.
module seq_receive_window_tracker
	import srwt_pkg::*;
#(
	parameter int unsigned MAX_WINDOW_BITS = DEF_MAX_WINDOW_BITS,
	parameter int unsigned SEQ_SPACE_MAX   = DEF_SEQ_SPACE_MAX
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  logic       start,
	output logic       busy,
	output result_t    result,
	output logic       done,
	input  logic       cfg_we,
	input  logic [8:0] cfg_wdata
);

	localparam int unsigned WIN_CAP   = (MAX_WINDOW_BITS > 511) ? 511 : MAX_WINDOW_BITS;
	localparam int unsigned MAP_DEPTH = WIN_CAP / 8;
	localparam logic [8:0]  WIN_CAP_L = 9'(WIN_CAP);
	localparam logic [15:0] SEQ_MAX   = 16'(SEQ_SPACE_MAX);
	localparam logic [15:0] SEQ_HALF  = 16'(SEQ_SPACE_MAX / 2);

	function automatic logic [8:0] clamp_win(input logic [8:0] v);
		logic [8:0] w;
		w = v;
		if (w < 9'd8) w = 9'd8;
		if (w > WIN_CAP_L) w = WIN_CAP_L;
		return w & 9'h1f8;
	endfunction

	function automatic logic [3:0] ones_run(input logic [7:0] v);
		logic [3:0] n;
		logic       stop;
		n = 4'd0;
		stop = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (!stop && v[i]) n = n + 4'd1;
			else stop = 1'b1;
		end
		return n;
	endfunction

	localparam logic [8:0] WIN_RESET = clamp_win(9'd256);

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_OFF   = 13'b0000000000010,
		S_END   = 13'b0000000000100,
		S_CLASS = 13'b0000000001000,
		S_SET   = 13'b0000000010000,
		S_SCAN0 = 13'b0000000100000,
		S_SCAN  = 13'b0000001000000,
		S_RED1  = 13'b0000010000000,
		S_RED2  = 13'b0000100000000,
		S_STEP  = 13'b0001000000000,
		S_SH0   = 13'b0010000000000,
		S_SH    = 13'b0100000000000,
		S_SPARE = 13'b1000000000000
	} state_t;

	state_t      state_q, state_d;
	cmd_t        item_q;
	logic [8:0]  window_q;
	logic [15:0] start_q, start_d;
	logic [15:0] rend_q, rend_d;
	logic [15:0] off_q, off_d;
	logic [15:0] eoff_q, eoff_d;
	logic [15:0] acc_q, acc_d;
	logic [8:0]  run_q, run_d;
	logic [1:0]  cls_q, cls_d;
	logic        rcv_q, rcv_d;
	logic [5:0]  cur_q, cur_d;
	logic [7:0]  raddr_q, raddr_d;
	logic [5:0]  wcnt_q, wcnt_d;
	logic [7:0]  lo_q, lo_d;
	logic        running_q, running_d;
	logic        done_q;
	result_t     res_q;
	logic        fin;

	logic [15:0] ua, ub, uy;
	logic        usub;
	logic [15:0] new_start;
	logic [5:0]  nbytes;
	logic [7:0]  rd_idx;
	logic [7:0]  rdata;
	map_req_t    req;
	logic [7:0]  byte_v;
	logic [3:0]  tcnt;
	logic [2:0]  shift_r;

	assign nbytes  = window_q[8:3];
	assign shift_r = item_q.advance_count[2:0];

	srwt_mod_unit #(.SEQ_SPACE_MAX(SEQ_SPACE_MAX)) u_mod (
		.a   (ua),
		.b   (ub),
		.sub (usub),
		.y   (uy)
	);

	srwt_map_mem #(.DEPTH(MAP_DEPTH)) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (rdata)
	);

	// Operand select for the shared modular unit
	always_comb begin
		ua = 16'd0;
		ub = 16'd0;
		usub = 1'b0;
		unique case (state_q)
			S_OFF: begin
				ua = item_q.seq_number;
				ub = start_q;
				usub = 1'b1;
			end
			S_END: begin
				ua = rend_q;
				ub = start_q;
				usub = 1'b1;
			end
			S_RED1: begin
				ua = {7'd0, item_q.advance_count};
			end
			S_RED2: begin
				ua = acc_q;
			end
			S_STEP: begin
				ua = start_q;
				ub = acc_q;
			end
			default: begin
			end
		endcase
	end

	assign new_start = (uy == 16'd0) ? SEQ_MAX : uy;

	always_comb begin
		state_d   = state_q;
		start_d   = start_q;
		rend_d    = rend_q;
		off_d     = off_q;
		eoff_d    = eoff_q;
		acc_d     = acc_q;
		run_d     = run_q;
		cls_d     = cls_q;
		rcv_d     = rcv_q;
		cur_d     = cur_q;
		raddr_d   = raddr_q;
		wcnt_d    = wcnt_q;
		lo_d      = lo_q;
		running_d = running_q;
		fin       = 1'b0;
		rd_idx    = 8'd0;
		byte_v    = 8'h00;
		tcnt      = 4'd0;
		req       = '0;

		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_OFF;
			end
			S_OFF: begin
				cls_d = CLS_IN_RANGE;
				rcv_d = 1'b0;
				if (item_q.kind == KIND_ARRIVAL) begin
					if (item_q.seq_number == 16'd0 || item_q.seq_number > SEQ_MAX) begin
						cls_d = CLS_OUTSIDE;
						fin = 1'b1;
					end else if (start_q == 16'd0) begin
						// First frame opens the window at position zero
						start_d = item_q.seq_number;
						rend_d  = item_q.seq_number;
						off_d   = 16'd0;
						cls_d   = CLS_IN_WINDOW;
						rd_idx  = 8'd0;
						state_d = S_SET;
					end else begin
						off_d   = uy;
						state_d = S_END;
					end
				end else if (start_q == 16'd0) begin
					fin = 1'b1;
				end else begin
					state_d = S_END;
				end
			end
			S_END: begin
				eoff_d = uy;
				state_d = (item_q.kind == KIND_ARRIVAL) ? S_CLASS : S_RED1;
			end
			S_CLASS: begin
				if (off_q > SEQ_HALF) begin
					cls_d = CLS_OLD;
					rcv_d = 1'b1;
					fin = 1'b1;
				end else if (off_q >= {7'd0, window_q}) begin
					cls_d = CLS_OUTSIDE;
					fin = 1'b1;
				end else begin
					rd_idx = 8'(off_q[8:3]);
					if (off_q <= eoff_q) begin
						cls_d = CLS_IN_RANGE;
					end else begin
						cls_d  = CLS_IN_WINDOW;
						rend_d = item_q.seq_number;
					end
					state_d = S_SET;
				end
			end
			S_SET: begin
				rcv_d = (cls_q == CLS_IN_RANGE) && rdata[off_q[2:0]];
				req.wr_en   = 1'b1;
				req.wr_addr = 8'(off_q[8:3]);
				req.wr_data = rdata | (8'd1 << off_q[2:0]);
				state_d = S_SCAN0;
			end
			S_SCAN0: begin
				// Resume the run where it stood; bits were only added
				rd_idx  = 8'(run_q[8:3]);
				cur_d   = run_q[8:3];
				state_d = S_SCAN;
			end
			S_SCAN: begin
				rd_idx = 8'(cur_q) + 8'd1;
				byte_v = rdata | ((8'd1 << run_q[2:0]) - 8'd1);
				tcnt = ones_run(byte_v);
				if (tcnt == 4'd8 && ({1'b0, cur_q} + 7'd1) < {1'b0, nbytes}) begin
					cur_d = cur_q + 6'd1;
					run_d = {cur_q + 6'd1, 3'b000};
				end else begin
					run_d = {cur_q, 3'b000} + 9'(tcnt);
					fin = 1'b1;
				end
			end
			S_RED1: begin
				acc_d = uy;
				state_d = S_RED2;
			end
			S_RED2: begin
				acc_d = uy;
				state_d = S_STEP;
			end
			S_STEP: begin
				start_d = new_start;
				if ({7'd0, item_q.advance_count} > eoff_q) rend_d = new_start;
				if (item_q.advance_count >= window_q) begin
					// Slide past the whole window: drop every mark
					req.clear = 1'b1;
					run_d = 9'd0;
					fin = 1'b1;
				end else begin
					rd_idx  = 8'(item_q.advance_count[8:3]);
					raddr_d = 8'(item_q.advance_count[8:3]) + 8'd1;
					state_d = S_SH0;
				end
			end
			S_SH0: begin
				lo_d      = rdata;
				rd_idx    = raddr_q;
				raddr_d   = raddr_q + 8'd1;
				wcnt_d    = 6'd0;
				run_d     = 9'd0;
				running_d = 1'b1;
				state_d   = S_SH;
			end
			S_SH: begin
				byte_v = 8'({rdata, lo_q} >> shift_r);
				tcnt = ones_run(byte_v);
				req.wr_en   = 1'b1;
				req.wr_addr = 8'(wcnt_q);
				req.wr_data = byte_v;
				lo_d    = rdata;
				rd_idx  = raddr_q;
				raddr_d = raddr_q + 8'd1;
				if (running_q) begin
					run_d = run_q + 9'(tcnt);
					running_d = (tcnt == 4'd8);
				end
				if (wcnt_q == nbytes - 6'd1) begin
					fin = 1'b1;
				end else begin
					wcnt_d = wcnt_q + 6'd1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (fin) state_d = S_IDLE;

		if (cfg_we) begin
			start_d = 16'd0;
			rend_d  = 16'd0;
			run_d   = 9'd0;
			req.clear = 1'b1;
		end

		req.rd_addr = rd_idx;
		req.rd_ok   = rd_idx < {2'b00, nbytes};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			window_q <= WIN_RESET;
			start_q  <= 16'd0;
			rend_q   <= 16'd0;
			run_q    <= 9'd0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			start_q <= start_d;
			rend_q  <= rend_d;
			run_q   <= run_d;
			if (cfg_we) window_q <= clamp_win(cfg_wdata);
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == S_IDLE) item_q <= cmd;
		off_q     <= off_d;
		eoff_q    <= eoff_d;
		acc_q     <= acc_d;
		cls_q     <= cls_d;
		rcv_q     <= rcv_d;
		cur_q     <= cur_d;
		raddr_q   <= raddr_d;
		wcnt_q    <= wcnt_d;
		lo_q      <= lo_d;
		running_q <= running_d;
		if (fin) begin
			res_q.window_class     <= cls_d;
			res_q.was_received     <= rcv_d;
			res_q.contiguous_count <= run_d;
			res_q.window_start     <= start_d;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a preceding busy cycle");

	a_run_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		run_q <= window_q)
		else $error("contiguous run exceeds window size");

	a_window_legal: assert property (@(posedge clk) disable iff (!arst_n)
		window_q[2:0] == 3'd0 && window_q >= 9'd8)
		else $error("window size not clamped");

	a_range_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		start_q == 16'd0 |-> rend_q == 16'd0)
		else $error("range end set before the window started");

	a_old_is_received: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.window_class == CLS_OLD |-> result.was_received)
		else $error("old frame not reported as received");

endmodule

### tb/sv/seq_receive_window_tracker_tb.sv
// Self-checking testbench for the receive-window tracker: directed and random
// arrival/advance beats, checked against an in-bench predictor of the window.
// Depends on srwt_pkg and seq_receive_window_tracker.
`timescale 1ns / 1ps

module seq_receive_window_tracker_tb
	import srwt_pkg::*;
();

	localparam int unsigned SEQ_SPACE   = DEF_SEQ_SPACE_MAX;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned ITEMS_PER_PHASE = 250;

	// Predicts window state and queues the expected result of each command beat.
	class window_scoreboard;
		int unsigned win_bits;
		int unsigned start_seq;
		int unsigned range_end;
		bit [255:0]  rx_map;
		result_t     pending[$];
		int unsigned errors;

		function new();
			errors = 0;
			set_window(9'd256);
		endfunction

		// Clamp, round down to a byte and restart the tracker
		function void set_window(logic [8:0] v);
			int unsigned w;
			w = v;
			if (w < 8) w = 8;
			if (w > DEF_MAX_WINDOW_BITS) w = DEF_MAX_WINDOW_BITS;
			win_bits  = w & ~32'd7;
			start_seq = 0;
			range_end = 0;
			rx_map    = '0;
		endfunction

		function int unsigned ahead(int unsigned x);
			return (x + SEQ_SPACE - start_seq) % SEQ_SPACE;
		endfunction

		function int unsigned run_len();
			int unsigned p;
			p = 0;
			if (start_seq == 0) return 0;
			while (p < win_bits && rx_map[p]) p++;
			return p;
		endfunction

		function void note_cmd(cmd_t c);
			result_t     r;
			int unsigned seq, off, end_off, span;
			r = '0;
			seq = c.seq_number;
			if (c.kind == KIND_ARRIVAL) begin
				if (seq == 0) begin
					r.window_class = CLS_OUTSIDE;
				end else if (start_seq == 0) begin
					r.window_class = CLS_IN_WINDOW;
					start_seq = seq;
					range_end = seq;
					rx_map[0] = 1'b1;
				end else begin
					off = ahead(seq);
					end_off = ahead(range_end);
					if (off > SEQ_SPACE / 2) begin
						r.window_class = CLS_OLD;
						r.was_received = 1'b1;
					end else if (off >= win_bits) begin
						r.window_class = CLS_OUTSIDE;
					end else if (off <= end_off) begin
						r.window_class = CLS_IN_RANGE;
						r.was_received = rx_map[off];
						rx_map[off] = 1'b1;
					end else begin
						r.window_class = CLS_IN_WINDOW;
						rx_map[off] = 1'b1;
						range_end = seq;
					end
				end
			end else if (start_seq != 0) begin
				span = ahead(range_end) + 1;
				// bits at or above the window are always clear, so a plain shift will do
				if (c.advance_count >= win_bits) rx_map = '0;
				else rx_map = rx_map >> c.advance_count;
				start_seq = ((start_seq - 1 + c.advance_count % SEQ_SPACE) % SEQ_SPACE) + 1;
				if (c.advance_count >= span) range_end = start_seq;
			end
			r.contiguous_count = 9'(run_len());
			r.window_start = 16'(start_seq);
			pending.push_back(r);
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, actual %p", $time, got);
				return;
			end
			want = pending.pop_front();
			check_field("window_class", want.window_class, got.window_class);
			check_field("was_received", want.was_received, got.was_received);
			check_field("contiguous_count", want.contiguous_count, got.contiguous_count);
			check_field("window_start", want.window_start, got.window_start);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	cmd_t        cmd_beat;
	logic        start;
	logic        busy;
	result_t     res_beat;
	logic        done;
	logic        cfg_we;
	logic [8:0]  cfg_wdata;

	window_scoreboard sb;
	int unsigned      idle_pct;
	int unsigned      stall_cycles;

	seq_receive_window_tracker u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_beat),
		.start     (start),
		.busy      (busy),
		.result    (res_beat),
		.done      (done),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// Check result beats and watch for a stalled handshake
	always @(posedge clk) begin
		if (done) sb.check_result(res_beat);
		if ((start && !busy) || done) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
				$display("seq_receive_window_tracker_tb NOT OK");
				$finish;
			end
		end
	end

	function automatic logic [15:0] seq_at(int unsigned off);
		return 16'(((sb.start_seq - 1 + off) % SEQ_SPACE) + 1);
	endfunction

	task automatic send(logic kind, logic [15:0] seq, logic [8:0] cnt);
		cmd_t c;
		c.kind = kind;
		c.seq_number = seq;
		c.advance_count = cnt;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		cmd_beat = c;
		start = 1'b1;
		do @(posedge clk); while (busy);
		sb.note_cmd(c);
	endtask

	// Hold off the sender until every expected result has come back
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic set_window(logic [8:0] v);
		drain();
		// let the tail of the last command finish before restarting
		repeat (40) @(negedge clk);
		cfg_wdata = v;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_window(v);
	endtask

	function automatic cmd_t pick_item();
		cmd_t        c;
		int unsigned r, w, run;
		c.kind = KIND_ARRIVAL;
		c.seq_number = 16'($urandom);
		c.advance_count = 9'($urandom);
		r = $urandom_range(99);
		w = sb.win_bits;
		run = sb.run_len();
		if (sb.start_seq == 0) begin
			if (r < 5) c.seq_number = '0;
			else c.seq_number = 16'($urandom_range(SEQ_SPACE, 1));
		end else if (r < 45) begin
			// grow the contiguous run from its frontier
			c.seq_number = seq_at(run + $urandom_range(2));
		end else if (r < 65) begin
			c.seq_number = seq_at($urandom_range(w - 1));
		end else if (r < 82) begin
			c.kind = KIND_ADVANCE;
			c.advance_count = 9'($urandom_range(run));
		end else if (r < 88) begin
			c.kind = KIND_ADVANCE;
		end else if (r < 94) begin
			c.seq_number = seq_at($urandom_range(w + 4, w - 4));
		end else if (r < 97) begin
			c.seq_number = seq_at(SEQ_SPACE - $urandom_range(40, 1));
		end else if (r < 98) begin
			c.seq_number = '0;
		end
		return c;
	endfunction

	initial begin
		int unsigned window_plan[6];
		cmd_t        c;
		window_plan = '{0, 100, 511, 15, 64, 256};
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cmd_beat = '0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		idle_pct = 11;
		stall_cycles = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed beats at the reset window size
		send(KIND_ADVANCE, 16'hffff, 9'd5);       // advance before start: ignored
		send(KIND_ARRIVAL, 16'd0, 9'd0);          // invalid before start
		send(KIND_ARRIVAL, 16'd65530, 9'd0);      // first frame
		send(KIND_ARRIVAL, 16'd65530, 9'd0);      // duplicate of the start
		send(KIND_ARRIVAL, seq_at(1), 9'd0);
		send(KIND_ARRIVAL, seq_at(5), 9'd0);      // top of sequence space
		send(KIND_ARRIVAL, seq_at(6), 9'd0);      // wraps past zero
		send(KIND_ARRIVAL, seq_at(3), 9'd0);      // gap inside the range
		send(KIND_ARRIVAL, seq_at(255), 9'd0);    // last window position
		send(KIND_ARRIVAL, seq_at(256), 9'd0);    // just past the window
		send(KIND_ARRIVAL, seq_at(32767), 9'd0);  // half-space edge, still ahead
		send(KIND_ARRIVAL, seq_at(32768), 9'd0);  // half-space edge, behind
		send(KIND_ARRIVAL, seq_at(65534), 9'd0);  // one behind the start
		send(KIND_ARRIVAL, 16'd0, 9'd0);          // invalid after start
		send(KIND_ADVANCE, 16'd0, 9'd0);
		send(KIND_ADVANCE, 16'd0, 9'd1);
		send(KIND_ADVANCE, 16'd0, 9'd3);
		send(KIND_ARRIVAL, seq_at(0), 9'd0);
		send(KIND_ADVANCE, 16'd0, 9'd8);
		send(KIND_ADVANCE, 16'd0, 9'd200);        // stays short of the range end
		send(KIND_ARRIVAL, seq_at(4), 9'd0);
		send(KIND_ADVANCE, 16'd0, 9'd256);        // clears the whole window
		send(KIND_ARRIVAL, seq_at(1), 9'd0);
		send(KIND_ADVANCE, 16'd0, 9'd511);
		send(KIND_ARRIVAL, seq_at(0), 9'd0);

		for (int ph = 0; ph < 6; ph++) begin
			idle_pct = (ph < 2) ? 11 : (ph < 4) ? 79 : 0;
			set_window(9'(window_plan[ph]));
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (i == 120) drain();
				c = pick_item();
				send(c.kind, c.seq_number, c.advance_count);
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("seq_receive_window_tracker_tb OK");
		end else begin
			$display("seq_receive_window_tracker_tb NOT OK");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/srwt_pkg.sv
hw/rtl/srwt_mod_unit.sv
hw/rtl/srwt_map_mem.sv
hw/rtl/seq_receive_window_tracker.sv
tb/sv/seq_receive_window_tracker_tb.sv
